@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/msh_pkg.sv @@
// ----------------------------------------------------------------------------
// msh_pkg
// Types and codes used by the heap manager.
// ----------------------------------------------------------------------------
package msh_pkg;

   localparam int MAX_SLOTS = 64;

   typedef enum logic [2:0] {
      FUNC_ALLOC  = 3'd0,
      FUNC_FREE   = 3'd1,
      FUNC_LINK   = 3'd2,
      FUNC_UNLINK = 3'd3,
      FUNC_GC     = 3'd4,
      FUNC_CHECK  = 3'd5,
      FUNC_QUERY  = 3'd6,
      FUNC_NONE   = 3'd7
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_MARK_INIT,
      ST_MARK_POP,
      ST_MARK_READ,
      ST_MARK_SCAN,
      ST_SWEEP_SEL,
      ST_SWEEP_ROW,
      ST_SWEEP_NEXT,
      ST_QUERY,
      ST_DONE
   } state_type;

endpackage

@@ design/mark_sweep_heap_manager.sv @@
// ----------------------------------------------------------------------------
// mark_sweep_heap_manager
// Object heap with a reference matrix, alloc/free/link/unlink/gc/check/query and error counters.
// ----------------------------------------------------------------------------
// One request word is taken at a time and answered by exactly one response
// word. After reset the block clears the edge memory one row a cycle, so
// requests are stalled until the clear is done. Alloc scans one slot a
// cycle. Free and gc first mark reachable slots: each popped slot has its
// row read and then its columns scanned one per cycle. Sweeping then visits
// each freed slot and walks all SLOTS rows, reading each row and then
// writing it back: the freed slot's own row is cleared, and its column is
// cleared in every other unmarked row but row 0. The edge memory has one
// row read port and one row write port. req_stall is high while busy and
// while an unread response is held.
module mark_sweep_heap_manager #(
   parameter int SLOTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  msh_pkg::func_type   req_func,
   input  logic signed [7:0]   req_addr_a,
   input  logic [5:0]          req_addr_b,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [5:0]          rsp_alloc_addr,
   output logic                rsp_edge_set,
   output logic                rsp_slot_exists,
   output logic [31:0]         rsp_seg_fault_count,
   output logic [31:0]         rsp_null_access_count,
   output logic [31:0]         rsp_out_of_bounds_count,
   output logic [31:0]         rsp_out_of_memory_count
);
   import msh_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = $clog2(SLOTS + 1);
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   // Edge memory: row r holds the outgoing edges of slot r.
   logic [SLOTS-1:0] edge_mem [SLOTS];
   logic [IW-1:0]    walk_mem [SLOTS];

   state_type        state_ff, state_in;
   func_type         func_ff, func_in;
   logic [IW-1:0]    slot_a_ff, slot_a_in;
   logic [IW-1:0]    slot_b_ff, slot_b_in;
   logic             a_ok_ff, a_ok_in;
   logic             b_ok_ff, b_ok_in;
   logic [SLOTS-1:0] exists_ff, exists_in;
   logic [SLOTS-1:0] mark_ff, mark_in;
   logic [PW-1:0]    sp_ff, sp_in;
   logic [IW-1:0]    idx_ff, idx_in;     // column / row / alloc cursor
   logic [IW-1:0]    victim_ff, victim_in;
   logic [SLOTS-1:0] row_ff;             // registered row read
   logic [5:0]       alloc_ff, alloc_in;
   logic             edge_ff, edge_in;
   logic [31:0]      cnt_ff [4];
   logic [31:0]      cnt_in [4];
   logic             rsp_valid_ff, rsp_valid_in;

   // Memory port controls.
   logic             mem_we;
   logic [IW-1:0]    mem_waddr;
   logic [SLOTS-1:0] mem_wdata;
   logic [IW-1:0]    mem_raddr;
   logic             row_load;
   logic             stk_we;
   logic [IW-1:0]    stk_waddr;
   logic [IW-1:0]    stk_wdata;
   logic [IW-1:0]    stk_raddr;
   logic [IW-1:0]    stk_rdata_ff;

   logic             accept;
   logic             rsp_take;
   logic             last_idx;

   assign accept   = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign last_idx = (idx_ff == IW'(SLOTS - 1));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         edge_mem[mem_waddr] <= mem_wdata;
      end
      if (row_load) begin
         row_ff <= edge_mem[mem_raddr];
      end
      if (stk_we) begin
         walk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= walk_mem[stk_raddr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (last_idx) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_ALLOC: state_in = ST_ALLOC;
                  FUNC_GC:    state_in = ST_MARK_INIT;
                  FUNC_FREE: begin
                     if ((req_addr_a >= 0) && (req_addr_a < SLOTS) && (req_addr_a != 0)) begin
                        state_in = ST_MARK_INIT;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default:    state_in = ST_QUERY;
               endcase
            end
         end
         ST_ALLOC: begin
            if (!exists_ff[idx_ff] || last_idx) begin
               state_in = ST_DONE;
            end
         end
         ST_MARK_INIT: state_in = ST_MARK_POP;
         ST_MARK_POP: begin
            if (sp_ff == '0) begin
               state_in = ST_SWEEP_SEL;
            end else begin
               state_in = ST_MARK_READ;
            end
         end
         ST_MARK_READ: state_in = ST_MARK_SCAN;
         ST_MARK_SCAN: begin
            if (last_idx) begin
               state_in = ST_MARK_POP;
            end
         end
         ST_SWEEP_SEL: begin
            if (func_ff == FUNC_FREE) begin
               state_in = ST_SWEEP_ROW;
            end else if (!mark_ff[idx_ff] && (idx_ff != '0)) begin
               state_in = ST_SWEEP_ROW;
            end else if (last_idx) begin
               state_in = ST_DONE;
            end
         end
         ST_SWEEP_ROW: state_in = ST_SWEEP_NEXT;
         ST_SWEEP_NEXT: begin
            if (last_idx) begin
               if (func_ff == FUNC_FREE || victim_ff == IW'(SLOTS - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SWEEP_SEL;
               end
            end else begin
               state_in = ST_SWEEP_ROW;
            end
         end
         ST_QUERY: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      func_in      = func_ff;
      slot_a_in    = slot_a_ff;
      slot_b_in    = slot_b_ff;
      a_ok_in      = a_ok_ff;
      b_ok_in      = b_ok_ff;
      exists_in    = exists_ff;
      mark_in      = mark_ff;
      sp_in        = sp_ff;
      idx_in       = idx_ff;
      victim_in    = victim_ff;
      alloc_in     = alloc_ff;
      edge_in      = edge_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = row_ff;
      mem_raddr    = idx_ff;
      row_load     = 1'b1;
      stk_we       = 1'b0;
      stk_waddr    = sp_ff[IW-1:0];
      stk_wdata    = idx_ff;
      stk_raddr    = IW'(sp_ff - PW'(1));
      case (state_ff)
         ST_CLEAR: begin
            // Every row starts empty; one row is cleared per cycle.
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = '0;
            idx_in    = idx_ff + IW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               func_in   = req_func;
               a_ok_in   = (req_addr_a >= 0) && (req_addr_a < SLOTS);
               b_ok_in   = ({2'b00, req_addr_b} < 8'(SLOTS));
               slot_a_in = IW'(req_addr_a[5:0]);
               slot_b_in = IW'(req_addr_b);
               alloc_in  = '0;
               edge_in   = 1'b0;
               idx_in    = IW'(1);
            end
         end
         ST_ALLOC: begin
            if (!exists_ff[idx_ff]) begin
               exists_in[idx_ff] = 1'b1;
               alloc_in = 6'(idx_ff);
            end else if (last_idx) begin
               cnt_in[3] = (cnt_ff[3] == CNT_MAX) ? cnt_ff[3] : cnt_ff[3] + 32'd1;
            end
            idx_in = idx_ff + IW'(1);
         end
         ST_MARK_INIT: begin
            mark_in   = '0;
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = '0;
            sp_in     = PW'(1);
         end
         ST_MARK_POP: begin
            // Stack read of the top entry is registered this cycle.
            if (sp_ff != '0) begin
               sp_in = sp_ff - PW'(1);
            end else begin
               idx_in = (func_ff == FUNC_FREE) ? '0 : '0;
               victim_in = slot_a_ff;
            end
         end
         ST_MARK_READ: begin
            mem_raddr = stk_rdata_ff;
            idx_in    = '0;
         end
         ST_MARK_SCAN: begin
            // The popped slot's row must stay put for the whole scan.
            row_load = 1'b0;
            if (!mark_ff[idx_ff] && row_ff[idx_ff]) begin
               mark_in[idx_ff] = 1'b1;
               stk_we    = 1'b1;
               stk_waddr = sp_ff[IW-1:0];
               stk_wdata = idx_ff;
               sp_in     = sp_ff + PW'(1);
            end
            idx_in = idx_ff + IW'(1);
         end
         ST_SWEEP_SEL: begin
            if (func_ff == FUNC_FREE) begin
               victim_in = slot_a_ff;
               idx_in    = '0;
            end else if (!mark_ff[idx_ff] && (idx_ff != '0)) begin
               victim_in = idx_ff;
               idx_in    = '0;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_SWEEP_ROW: begin
            mem_raddr = idx_ff;
         end
         ST_SWEEP_NEXT: begin
            // Row idx_ff is in row_ff; clear the victim's whole row, or its column in unmarked rows other than row 0.
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = row_ff;
            if (idx_ff == victim_ff) begin
               mem_wdata = '0;
            end else if (idx_ff != '0 && !mark_ff[idx_ff]) begin
               mem_wdata[victim_ff] = 1'b0;
            end
            if (last_idx) begin
               exists_in[victim_ff] = 1'b0;
               idx_in = victim_ff + IW'(1);
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_QUERY: begin
            // row_ff holds row slot_a (read on the accept edge path below).
            case (func_ff)
               FUNC_LINK: begin
                  if (a_ok_ff && b_ok_ff && exists_ff[slot_a_ff] && exists_ff[slot_b_ff]) begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_a_ff;
                     mem_wdata = row_ff | (SLOTS'(1) << slot_b_ff);
                  end
               end
               FUNC_UNLINK: begin
                  if (a_ok_ff && b_ok_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_a_ff;
                     mem_wdata = row_ff & ~(SLOTS'(1) << slot_b_ff);
                  end
               end
               FUNC_QUERY: begin
                  edge_in = a_ok_ff && b_ok_ff && row_ff[slot_b_ff];
               end
               FUNC_CHECK: begin
                  if (!a_ok_ff) begin
                     cnt_in[2] = (cnt_ff[2] == CNT_MAX) ? cnt_ff[2] : cnt_ff[2] + 32'd1;
                  end else if (!exists_ff[slot_a_ff]) begin
                     cnt_in[0] = (cnt_ff[0] == CNT_MAX) ? cnt_ff[0] : cnt_ff[0] + 32'd1;
                  end else if (slot_a_ff == '0) begin
                     cnt_in[1] = (cnt_ff[1] == CNT_MAX) ? cnt_ff[1] : cnt_ff[1] + 32'd1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
      if (state_ff == ST_IDLE) begin
         mem_raddr = IW'(req_addr_a[5:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         exists_ff    <= SLOTS'(1);
         mark_ff      <= '0;
         sp_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '{default: 32'd0};
      end else begin
         state_ff     <= state_in;
         exists_ff    <= exists_in;
         mark_ff      <= mark_in;
         sp_ff        <= sp_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      slot_a_ff <= slot_a_in;
      slot_b_ff <= slot_b_in;
      a_ok_ff   <= a_ok_in;
      b_ok_ff   <= b_ok_in;
      victim_ff <= victim_in;
      alloc_ff  <= alloc_in;
      edge_ff   <= edge_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_alloc_addr          = alloc_ff;
   assign rsp_edge_set            = edge_ff;
   assign rsp_slot_exists         = a_ok_ff && exists_ff[slot_a_ff];
   assign rsp_seg_fault_count     = cnt_ff[0];
   assign rsp_null_access_count   = cnt_ff[1];
   assign rsp_out_of_bounds_count = cnt_ff[2];
   assign rsp_out_of_memory_count = cnt_ff[3];

endmodule

@@ design/msh_checker.sv @@
// ----------------------------------------------------------------------------
// msh_checker
// Port-level checks of the heap manager's handshakes and counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module msh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_seg_fault_count,
   input logic [31:0] rsp_out_of_memory_count
);
   // A response word and an accepted request never coincide.
   `ASSERT_IMPLY(a_no_overlap, clock, reset, rsp_valid, req_stall)
   // A stalled response stays valid.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // The seg-fault and out-of-memory counters never decrease.
   `ASSERT_NEXT(a_seg_mono, clock, reset, 1'b1, rsp_seg_fault_count >= $past(rsp_seg_fault_count))
   `ASSERT_NEXT(a_oom_mono, clock, reset, 1'b1, rsp_out_of_memory_count >= $past(rsp_out_of_memory_count))
   // An accepted request is never answered in the next cycle.
   `ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, !rsp_valid)
endmodule

bind mark_sweep_heap_manager msh_checker u_msh_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_seg_fault_count    (rsp_seg_fault_count),
   .rsp_out_of_memory_count(rsp_out_of_memory_count)
);
